// ===== src/ddo_pkg.sv =====
// shared types, constants and tables for the differential drive odometry block
// no dependencies; imported by every module of the block
package ddo_pkg;

    // field and register widths
    localparam int TICK_W    = 16;
    localparam int PER_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 48;
    localparam int HEAD_W    = 32;
    localparam int LIN_W     = 32;
    localparam int ANGSPD_W  = 48;
    localparam int TANG_W    = 64;
    localparam int GAIN_W    = 24;

    // default parameter values
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_TICK_BITS    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_LEFT  = 32'd3217600;
    localparam logic [CFG_W-1:0] RST_RIGHT = 32'd3217600;
    localparam logic [CFG_W-1:0] RST_ANGLE = 32'd2357118;

    // cordic gain compensation, Q0.24
    localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10187873;

    // arctangent of 2^-i in binary angle units
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [TICK_W-1:0] ticks_left;
        logic signed [TICK_W-1:0] ticks_right;
        logic        [PER_W-1:0]  period_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]    pos_x_out;
        logic signed [POS_W-1:0]    pos_y_out;
        logic        [HEAD_W-1:0]   heading_out;
        logic signed [LIN_W-1:0]    linear_speed;
        logic signed [ANGSPD_W-1:0] angular_speed;
        logic signed [POS_W-1:0]    total_distance_out;
        logic signed [TANG_W-1:0]   total_angle_out;
        logic signed [POS_W-1:0]    total_left_ticks;
        logic signed [POS_W-1:0]    total_right_ticks;
    } t_out_item;

endpackage

// ===== src/ddo_mul.sv =====
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on ddo_pkg
module ddo_mul
    import ddo_pkg::*;
#(
    parameter int A_W = 48,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [A_W:0]     w_sum;
    logic [A_W-1:0]   n_hi;
    logic [B_W-1:0]   n_lo;

    // add the multiplicand when the low bit is set, then shift right
    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_hi  = w_sum[A_W:1];
        n_lo  = {w_sum[0], r_lo[B_W-1:1]};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_hi, r_lo};

endmodule

// ===== src/ddo_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on ddo_pkg
module ddo_div
    import ddo_pkg::*;
#(
    parameter int N_W = 66,
    parameter int D_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic [N_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_bit;
    logic [D_W-1:0]   n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_q[N_W-1]};
        w_diff  = w_trial - {1'b0, r_d};
        w_bit   = (w_trial >= {1'b0, r_d});
        n_rem   = w_bit ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[N_W-2:0], w_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// ===== src/ddo_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on ddo_pkg for the arctangent table and the default step count
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = DEF_CORDIC_STEPS,
    parameter int XY_W  = 50
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [XY_W-1:0] i_x0,
    input  logic [31:0]            i_angle,
    output logic                   o_busy,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y
);
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int Z_W   = 34;
    localparam logic signed [Z_W-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [Z_W-1:0] HALF    = 34'sd2147483648;

    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic [4:0]             w_idx;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic signed [Z_W-1:0]  w_t;
    logic signed [Z_W-1:0]  w_z0;
    logic signed [Z_W-1:0]  n_z0;
    logic signed [XY_W-1:0] n_x0;

    // fold the start angle into plus or minus a quarter turn
    always_comb begin
        w_z0 = Z_W'($signed(i_angle));
        n_z0 = w_z0;
        n_x0 = i_x0;
        if (w_z0 > QUARTER) begin
            n_z0 = w_z0 - HALF;
            n_x0 = -i_x0;
        end else if (w_z0 < -QUARTER) begin
            n_z0 = w_z0 + HALF;
            n_x0 = -i_x0;
        end
    end

    // shifted terms and table angle for this step
    always_comb begin
        w_idx = 5'(r_cnt);
        w_xs  = r_x >>> w_idx;
        w_ys  = r_y >>> w_idx;
        w_t   = $signed({2'b00, ATAN_TAB[w_idx]});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // micro-rotation toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= n_x0;
            r_y <= '0;
            r_z <= n_z0;
        end else if (r_busy) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_t;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_t;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// ===== src/differential_drive_odometry.sv =====
// top level of the differential drive odometry block: sequencer, state and ports
// depends on ddo_pkg, ddo_mul, ddo_div and ddo_cordic
// One request of left and right tick counts and a period gives one result with
// position, heading, speeds and running totals. A bit-serial multiply forms the
// heading change, then the bit-serial angular speed division runs alongside the
// cordic rotation. One request is in work at a time; the next request is taken
// while a finished result still waits in the output register. Configuration
// writes take effect at once; the user must make them only while the block is
// idle, and the block itself does not enforce this.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int TICK_BITS    = DEF_TICK_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int TW     = (TICK_BITS < TICK_W) ? TICK_BITS : TICK_W;
    localparam int XY_W   = 50;
    localparam int DA_W   = 57;
    localparam int DAM_W  = 56;
    localparam int DIFF_W = 49;
    localparam int LIN_N  = 42;
    localparam int ANG_N  = 66;
    localparam logic [LIN_N-1:0] LIN_MAX = 42'd2147483647;
    localparam logic [ANG_N-1:0] ANG_MAX = 66'd140737488355327;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PROD   = 9'b000000010,
        S_SCALE  = 9'b000000100,
        S_MSTART = 9'b000001000,
        S_LSTART = 9'b000010000,
        S_MWAIT  = 9'b000100000,
        S_ASTART = 9'b001000000,
        S_RWAIT  = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_W-1:0] r_left;
    logic [CFG_W-1:0] r_right;
    logic [CFG_W-1:0] r_angle;

    // odometry state
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic [HEAD_W-1:0]        r_heading;
    logic signed [POS_W-1:0]  r_sum_dist;
    logic signed [TANG_W-1:0] r_sum_angle;
    logic signed [POS_W-1:0]  r_sum_left;
    logic signed [POS_W-1:0]  r_sum_right;

    // request working registers
    logic signed [TW-1:0]     r_tl;
    logic signed [TW-1:0]     r_tr;
    logic [PER_W-1:0]         r_per;
    logic signed [POS_W-1:0]  r_dl;
    logic signed [POS_W-1:0]  r_dr;
    logic signed [POS_W-1:0]  r_d24;
    logic signed [POS_W-1:0]  r_d16;
    logic signed [DIFF_W-1:0] r_diff;
    logic [POS_W-1:0]         r_d24_mag;
    logic [DAM_W-1:0]         r_da_mag;
    logic signed [DA_W-1:0]   r_da;
    logic signed [XY_W-1:0]   r_x0;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // unit handshakes and results
    logic                     w_in_acc;
    logic                     w_mul_start;
    logic                     w_lin_start;
    logic                     w_rot_start;
    logic                     w_da_busy;
    logic                     w_x_busy;
    logic                     w_lin_busy;
    logic                     w_ang_busy;
    logic                     w_rot_busy;
    logic [POS_W+CFG_W-1:0]   w_da_prod;
    logic [POS_W+GAIN_W-1:0]  w_x_prod;
    logic [LIN_N-1:0]         w_lin_q;
    logic [ANG_N-1:0]         w_ang_q;
    logic signed [XY_W-1:0]   w_rx;
    logic signed [XY_W-1:0]   w_ry;

    logic signed [DIFF_W-1:0] w_sum;
    logic [POS_W-1:0]         w_diff_mag;
    logic [POS_W-1:0]         w_d24_mag;
    logic [57:0]              w_lin_num;
    logic [ANG_N-1:0]         w_ang_num;
    logic [DAM_W-1:0]         w_da_mag;
    logic [POS_W-1:0]         w_x0_mag;
    logic [HEAD_W-1:0]        w_mid;
    logic                     w_fin_go;
    logic signed [XY_W-1:0]   w_xsh;
    logic signed [XY_W-1:0]   w_ysh;
    logic signed [LIN_W-1:0]  w_lin;
    logic signed [ANGSPD_W-1:0] w_ang;
    logic signed [POS_W-1:0]  n_pos_x;
    logic signed [POS_W-1:0]  n_pos_y;
    logic [HEAD_W-1:0]        n_heading;
    logic signed [POS_W-1:0]  n_sum_dist;
    logic signed [TANG_W-1:0] n_sum_angle;
    logic signed [POS_W-1:0]  n_sum_left;
    logic signed [POS_W-1:0]  n_sum_right;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_mul_start = (r_state == S_MSTART);
    assign w_lin_start = (r_state == S_LSTART);
    assign w_rot_start = (r_state == S_ASTART);
    assign w_fin_go    = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= RST_LEFT;
            r_right <= RST_RIGHT;
            r_angle <= RST_ANGLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEFT:  r_left  <= i_cfg_data;
                CFG_RIGHT: r_right <= i_cfg_data;
                CFG_ANGLE: r_angle <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // travel sum, mean and difference magnitudes, serial operands, mid heading
    always_comb begin
        w_sum      = DIFF_W'(r_dl) + DIFF_W'(r_dr);
        w_diff_mag = r_diff[DIFF_W-1] ? POS_W'(-r_diff) : r_diff[POS_W-1:0];
        w_d24_mag  = r_d24[POS_W-1] ? POS_W'(-r_d24) : r_d24;
        w_lin_num  = (58'(r_d24_mag) << 10) - (58'(r_d24_mag) << 4)
                   - (58'(r_d24_mag) << 3);
        w_ang_num  = (ANG_N'(r_da_mag) << 10) - (ANG_N'(r_da_mag) << 4)
                   - (ANG_N'(r_da_mag) << 3);
        w_da_mag   = w_da_prod[POS_W+CFG_W-1:24];
        w_x0_mag   = w_x_prod[POS_W+GAIN_W-1:24];
        w_mid      = r_heading + HEAD_W'(r_da >>> 1);
    end

    // saturated speeds, zero for a zero period
    always_comb begin
        w_lin = '0;
        w_ang = '0;
        if (r_per != '0) begin
            if (r_d24[POS_W-1]) begin
                w_lin = (w_lin_q > LIN_MAX) ? {1'b1, {(LIN_W-1){1'b0}}}
                                            : -$signed(w_lin_q[LIN_W-1:0]);
            end else begin
                w_lin = (w_lin_q > LIN_MAX) ? {1'b0, {(LIN_W-1){1'b1}}}
                                            : $signed(w_lin_q[LIN_W-1:0]);
            end
            if (r_da[DA_W-1]) begin
                w_ang = (w_ang_q > ANG_MAX) ? {1'b1, {(ANGSPD_W-1){1'b0}}}
                                            : -$signed(w_ang_q[ANGSPD_W-1:0]);
            end else begin
                w_ang = (w_ang_q > ANG_MAX) ? {1'b0, {(ANGSPD_W-1){1'b1}}}
                                            : $signed(w_ang_q[ANGSPD_W-1:0]);
            end
        end
    end

    // next odometry state
    always_comb begin
        w_xsh       = w_rx >>> 8;
        w_ysh       = w_ry >>> 8;
        n_pos_x     = r_pos_x + w_xsh[POS_W-1:0];
        n_pos_y     = r_pos_y + w_ysh[POS_W-1:0];
        n_heading   = r_heading + r_da[HEAD_W-1:0];
        n_sum_dist  = r_sum_dist + r_d16;
        n_sum_angle = r_sum_angle + TANG_W'(r_da);
        n_sum_left  = r_sum_left + POS_W'(r_tl);
        n_sum_right = r_sum_right + POS_W'(r_tr);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (w_in_acc) r_state <= S_PROD;
                S_PROD:   r_state <= S_SCALE;
                S_SCALE:  r_state <= S_MSTART;
                S_MSTART: r_state <= S_LSTART;
                S_LSTART: r_state <= S_MWAIT;
                S_MWAIT:  if (!w_da_busy && !w_x_busy) r_state <= S_ASTART;
                S_ASTART: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (!w_rot_busy && !w_lin_busy && !w_ang_busy) r_state <= S_FIN;
                end
                S_FIN:    if (w_fin_go) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tl  <= i_in_data.ticks_left[TW-1:0];
            r_tr  <= i_in_data.ticks_right[TW-1:0];
            r_per <= i_in_data.period_ms;
        end
        if (r_state == S_PROD) begin
            r_dl <= POS_W'(DIFF_W'(r_tl) * $signed({17'd0, r_left}));
            r_dr <= POS_W'(DIFF_W'(r_tr) * $signed({17'd0, r_right}));
        end
        if (r_state == S_SCALE) begin
            r_d24  <= POS_W'(w_sum >>> 1);
            r_d16  <= POS_W'(w_sum >>> 9);
            r_diff <= DIFF_W'(r_dr) - DIFF_W'(r_dl);
        end
        if (r_state == S_MSTART) begin
            r_d24_mag <= w_d24_mag;
        end
        if ((r_state == S_MWAIT) && !w_da_busy && !w_x_busy) begin
            r_da_mag <= w_da_mag;
            r_da     <= r_diff[DIFF_W-1] ? -DA_W'(w_da_mag) : DA_W'(w_da_mag);
            r_x0     <= r_d24[POS_W-1] ? -XY_W'(w_x0_mag) : XY_W'(w_x0_mag);
        end
    end

    // odometry state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_sum_dist  <= '0;
            r_sum_angle <= '0;
            r_sum_left  <= '0;
            r_sum_right <= '0;
        end else if (w_fin_go) begin
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_sum_dist  <= n_sum_dist;
            r_sum_angle <= n_sum_angle;
            r_sum_left  <= n_sum_left;
            r_sum_right <= n_sum_right;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out.pos_x_out          <= n_pos_x;
            r_out.pos_y_out          <= n_pos_y;
            r_out.heading_out        <= n_heading;
            r_out.linear_speed       <= w_lin;
            r_out.angular_speed      <= w_ang;
            r_out.total_distance_out <= n_sum_dist;
            r_out.total_angle_out    <= n_sum_angle;
            r_out.total_left_ticks   <= n_sum_left;
            r_out.total_right_ticks  <= n_sum_right;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // heading change multiply
    ddo_mul #(.A_W(POS_W), .B_W(CFG_W)) u_mul_da (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_diff_mag),
        .i_b     (r_angle),
        .o_busy  (w_da_busy),
        .o_prod  (w_da_prod)
    );

    // cordic gain compensation multiply
    ddo_mul #(.A_W(POS_W), .B_W(GAIN_W)) u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_d24_mag),
        .i_b     (GAIN_Q24),
        .o_busy  (w_x_busy),
        .o_prod  (w_x_prod)
    );

    // linear speed division
    ddo_div #(.N_W(LIN_N), .D_W(PER_W)) u_div_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lin_start),
        .i_num   (w_lin_num[57:16]),
        .i_den   (r_per),
        .o_busy  (w_lin_busy),
        .o_quot  (w_lin_q)
    );

    // angular speed division
    ddo_div #(.N_W(ANG_N), .D_W(PER_W)) u_div_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rot_start),
        .i_num   (w_ang_num),
        .i_den   (r_per),
        .o_busy  (w_ang_busy),
        .o_quot  (w_ang_q)
    );

    // position step rotation along the mid-period heading
    ddo_cordic #(.STEPS(CORDIC_STEPS), .XY_W(XY_W)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rot_start),
        .i_x0    (r_x0),
        .i_angle (w_mid),
        .o_busy  (w_rot_busy),
        .o_x     (w_rx),
        .o_y     (w_ry)
    );

endmodule

// ===== tb/tb_differential_drive_odometry.sv =====
// self-checking testbench for the differential drive odometry block
// depends on ddo_pkg and differential_drive_odometry; a built-in predictor checks untyped rows
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    localparam longint unsigned MAX_LIN = 64'd2147483647;
    localparam longint unsigned MAX_ANG = 64'd140737488355327;
    localparam int              SETTLE  = 300;
    localparam int              LIMIT   = 3000000;

    typedef struct {
        t_in_item  rq;
        bit        typed;
        t_out_item res;
    } t_odo_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LEFT;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // predictor copy of configuration and state
    logic [CFG_W-1:0]    left_scale = RST_LEFT;
    logic [CFG_W-1:0]    right_scale = RST_RIGHT;
    logic [CFG_W-1:0]    turn_scale = RST_ANGLE;
    logic [POS_W-1:0]    pos_x = '0;
    logic [POS_W-1:0]    pos_y = '0;
    logic [HEAD_W-1:0]   heading = '0;
    logic [POS_W-1:0]    dist_sum = '0;
    logic [TANG_W-1:0]   turn_sum = '0;
    logic [POS_W-1:0]    left_sum = '0;
    logic [POS_W-1:0]    right_sum = '0;

    t_odo_row  request_q[$];
    t_out_item pose_q[$];
    t_odo_row  drill_rows[$];
    t_odo_row  cur_row;
    bit        calm = 1'b0;
    int        mismatches = 0;
    int        cycles = 0;

    differential_drive_odometry u_dut (.*);

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // v * a / 2^24, truncated toward zero
    function automatic longint scale_q24(longint v, longint unsigned a);
        longint unsigned m;
        longint unsigned r;
        m = (v < 0) ? longint'(-v) : longint'(v);
        r = (m >> 24) * a + (((m & 64'hFFFFFF) * a) >> 24);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // v * 1000 / p truncated toward zero, saturated
    function automatic longint rate_of(longint v, longint unsigned p, longint unsigned lim);
        longint unsigned m;
        longint unsigned qh;
        longint unsigned r;
        longint unsigned cap;
        longint unsigned q;
        m = (v < 0) ? longint'(-v) : longint'(v);
        qh = m / p;
        r = m % p;
        cap = lim + ((v < 0) ? 1 : 0);
        if (qh > cap / 1000 + 1) begin
            q = cap;
        end else begin
            q = qh * 1000 + (r * 1000) / p;
            if (q > cap) q = cap;
        end
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // advance the pose by one request and return the expected result
    function automatic t_out_item advance_pose(t_in_item rq);
        longint    tl;
        longint    tr;
        longint    dl;
        longint    dr;
        longint    d24;
        longint    d16;
        longint    da;
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        longint    lin;
        longint    ang;
        logic [31:0] mid;
        t_out_item res;
        tl = longint'($signed(rq.ticks_left));
        tr = longint'($signed(rq.ticks_right));
        dl = tl * longint'({32'b0, left_scale});
        dr = tr * longint'({32'b0, right_scale});
        d24 = (dl + dr) >>> 1;
        d16 = (dl + dr) >>> 9;
        da = scale_q24(dr - dl, {32'b0, turn_scale});
        mid = heading + 32'(da >>> 1);
        z = longint'($signed(mid));
        x = scale_q24(d24, {40'b0, GAIN_Q24});
        y = 0;
        // fold into the right half plane
        if (z > 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            x = -x;
        end else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            x = -x;
        end
        for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
            xs = x >>> (i % 32);
            ys = y >>> (i % 32);
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({32'b0, ATAN_TAB[i % 32]});
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({32'b0, ATAN_TAB[i % 32]});
            end
        end
        pos_x = pos_x + 48'(x >>> 8);
        pos_y = pos_y + 48'(y >>> 8);
        heading = heading + 32'(da);
        dist_sum = dist_sum + 48'(d16);
        turn_sum = turn_sum + 64'(da);
        left_sum = left_sum + 48'(tl);
        right_sum = right_sum + 48'(tr);
        lin = 0;
        ang = 0;
        if (rq.period_ms != 0) begin
            lin = rate_of(d24, longint'({48'b0, rq.period_ms}) << 16, MAX_LIN);
            ang = rate_of(da, longint'({48'b0, rq.period_ms}), MAX_ANG);
        end
        res.pos_x_out = pos_x;
        res.pos_y_out = pos_y;
        res.heading_out = heading;
        res.linear_speed = lin[31:0];
        res.angular_speed = ang[47:0];
        res.total_distance_out = dist_sum;
        res.total_angle_out = turn_sum;
        res.total_left_ticks = left_sum;
        res.total_right_ticks = right_sum;
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // request side: predict on acceptance, then present the next request
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            t_out_item res;
            res = advance_pose(cur_row.rq);
            pose_q.push_back(cur_row.typed ? cur_row.res : res);
        end
        if (!i_in_valid || !o_in_stall) begin
            if (i_rst_n && request_q.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
                cur_row = request_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_data <= cur_row.rq;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side: compare with the oldest expectation, stall at random unless calm
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            t_out_item want;
            if (pose_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no request waiting");
            end else begin
                want = pose_q.pop_front();
                check_field("pos_x", 64'(want.pos_x_out), 64'(o_out_data.pos_x_out));
                check_field("pos_y", 64'(want.pos_y_out), 64'(o_out_data.pos_y_out));
                check_field("heading", 64'(want.heading_out), 64'(o_out_data.heading_out));
                check_field("linear_speed", 64'(want.linear_speed),
                            64'(o_out_data.linear_speed));
                check_field("angular_speed", 64'(want.angular_speed),
                            64'(o_out_data.angular_speed));
                check_field("total_distance", 64'(want.total_distance_out),
                            64'(o_out_data.total_distance_out));
                check_field("total_angle", want.total_angle_out,
                            o_out_data.total_angle_out);
                check_field("total_left", 64'(want.total_left_ticks),
                            64'(o_out_data.total_left_ticks));
                check_field("total_right", 64'(want.total_right_ticks),
                            64'(o_out_data.total_right_ticks));
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 20);
    end

    // timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (request_q.size() > 0 || i_in_valid || pose_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LEFT:  left_scale = val;
            CFG_RIGHT: right_scale = val;
            CFG_ANGLE: turn_scale = val;
            default: ;
        endcase
    endtask

    task automatic set_scales(logic [31:0] l, logic [31:0] r, logic [31:0] a);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_ANGLE, a);
    endtask

    function automatic t_odo_row plain(int tl, int tr, int per);
        t_odo_row row;
        row.rq.ticks_left = 16'(tl);
        row.rq.ticks_right = 16'(tr);
        row.rq.period_ms = 16'(per);
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    // random requests: mostly small motions, some extremes and full-range noise
    task automatic queue_random(int count);
        t_odo_row row;
        int       kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            if (kind < 6)
                row = plain($urandom_range(400) - 200, $urandom_range(400) - 200,
                            $urandom_range(50));
            else if (kind < 8)
                row = plain($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535));
            else
                row = plain(($urandom_range(1)) ? 32767 : -32768,
                            ($urandom_range(1)) ? 32767 : -32768, $urandom_range(3));
            request_q.push_back(row);
        end
    endtask

    initial begin
        t_odo_row row;
        // after reset all state is zero and a zero period gives zero speeds
        row = plain(0, 0, 0);
        row.typed = 1'b1;
        drill_rows.push_back(row);
        drill_rows.push_back(plain(1, 1, 1));
        drill_rows.push_back(plain(-32768, -32768, 65535));
        drill_rows.push_back(plain(32767, 32767, 1));
        drill_rows.push_back(plain(32767, -32768, 1));
        drill_rows.push_back(plain(-32768, 32767, 1));
        drill_rows.push_back(plain(-32768, 32767, 0));
        drill_rows.push_back(plain(100, -100, 10));
        drill_rows.push_back(plain(-100, 100, 10));
        // turn in steps through every quadrant of the heading
        for (int k = 0; k < 8; k++) drill_rows.push_back(plain(50, 2000, 20));
        drill_rows.push_back(plain(16'h5555, 16'hAAAA, 16'h5555));
        drill_rows.push_back(plain(16'hAAAA, 16'h5555, 16'hAAAA));
        drill_rows.push_back(plain(0, 0, 65535));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (drill_rows[i]) request_q.push_back(drill_rows[i]);
        queue_random(150);
        wait_idle();

        calm = 1'b1;
        set_scales(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        queue_random(200);
        wait_idle();
        calm = 1'b0;

        set_scales(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        queue_random(300);
        wait_idle();

        set_scales(32'd0, 32'd0, 32'd0);
        queue_random(100);
        wait_idle();

        set_scales(32'hFFFFFFFF, 32'd0, 32'd1);
        queue_random(150);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            set_scales($urandom, $urandom, $urandom);
            queue_random(130);
            wait_idle();
        end

        if (mismatches == 0 && pose_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== differential_drive_odometry.f =====
src/ddo_pkg.sv
src/ddo_mul.sv
src/ddo_div.sv
src/ddo_cordic.sv
src/differential_drive_odometry.sv
tb/tb_differential_drive_odometry.sv
